>>> rtl/core/loc_pkg.sv
// ----------------------------------------------------------------------------
// loc_pkg
// Shared types, sizes and helpers of the lru object cache.
// ----------------------------------------------------------------------------
`default_nettype none

package loc_pkg;

  localparam int LINES       = 10;
  localparam int KEY_WIDTH   = 32;
  localparam int VALUE_WIDTH = 32;
  localparam int IDX_W       = $clog2(LINES);
  localparam int ENTRY_W     = KEY_WIDTH + VALUE_WIDTH;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_STORE  = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [31:0] lookup_key;
    logic [31:0] store_value;
  } loc_req_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] read_value;
  } loc_res_t;

  // requests from the cache controller to the recency list
  typedef struct packed {
    logic             rd_victim;
    logic             promote;
    logic [IDX_W-1:0] target;
  } loc_lru_cmd_t;

  typedef struct packed {
    logic             ready;
    logic             victim_vld;
    logic [IDX_W-1:0] victim;
    logic             done;
  } loc_lru_sts_t;

  function automatic logic [KEY_WIDTH-1:0] to_key(input logic [31:0] k);
    logic [63:0] w;
    w = 64'(k);
    return w[KEY_WIDTH-1:0];
  endfunction

  function automatic logic [VALUE_WIDTH-1:0] to_value(input logic [31:0] v);
    logic [63:0] w;
    w = 64'(v);
    return w[VALUE_WIDTH-1:0];
  endfunction

  function automatic logic [31:0] from_value(input logic [VALUE_WIDTH-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return w[31:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/loc_ram.sv
// ----------------------------------------------------------------------------
// loc_ram
// Generic simple dual port RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module loc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/core/loc_lru.sv
// ----------------------------------------------------------------------------
// loc_lru
// Recency list held in a RAM: position 0 most recent. Fills the identity
// order after reset, reads the least-recent index and moves an index to the
// front by one walk from position 0, one position per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module loc_lru (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire loc_pkg::loc_lru_cmd_t cmd,
  output loc_pkg::loc_lru_sts_t      sts
);

  import loc_pkg::*;

  localparam logic [1:0] L_INIT = 2'd0;
  localparam logic [1:0] L_IDLE = 2'd1;
  localparam logic [1:0] L_VICT = 2'd2;
  localparam logic [1:0] L_MOVE = 2'd3;

  localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(LINES - 1);

  logic [1:0]       state_r, state_nxt;
  logic [IDX_W-1:0] pos_r, pos_nxt;
  logic [IDX_W-1:0] carry_r, carry_nxt;
  logic [IDX_W-1:0] tgt_r, tgt_nxt;

  logic             we;
  logic [IDX_W-1:0] waddr, wdata, raddr, rdata;
  logic             move_end;

  loc_ram #(.WIDTH(IDX_W), .DEPTH(LINES)) u_order_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // walk stops where the target was found, or at the tail
  assign move_end = (rdata == tgt_r) || (pos_r == LAST_POS);

  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    carry_nxt = carry_r;
    tgt_nxt   = tgt_r;
    we        = 1'b0;
    waddr     = pos_r;
    wdata     = carry_r;
    raddr     = pos_r + IDX_W'(1);
    sts       = '0;
    unique case (state_r)
      L_INIT: begin
        we    = 1'b1;
        wdata = pos_r;
        if (pos_r == LAST_POS) begin
          pos_nxt   = '0;
          state_nxt = L_IDLE;
        end else begin
          pos_nxt = pos_r + IDX_W'(1);
        end
      end
      L_IDLE, L_VICT: begin
        sts.ready      = (state_r == L_IDLE);
        sts.victim_vld = (state_r == L_VICT);
        sts.victim     = rdata;
        if (cmd.promote) begin
          raddr     = '0;
          pos_nxt   = '0;
          carry_nxt = cmd.target;
          tgt_nxt   = cmd.target;
          state_nxt = L_MOVE;
        end else if (cmd.rd_victim && state_r == L_IDLE) begin
          raddr     = LAST_POS;
          state_nxt = L_VICT;
        end else begin
          state_nxt = L_IDLE;
        end
      end
      L_MOVE: begin
        we = 1'b1;
        if (move_end) begin
          sts.done  = 1'b1;
          state_nxt = L_IDLE;
        end else begin
          carry_nxt = rdata;
          pos_nxt   = pos_r + IDX_W'(1);
        end
      end
      default: begin
        state_nxt = L_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_INIT;
      pos_r   <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
    end
    carry_r <= carry_nxt;
    tgt_r   <= tgt_nxt;
  end

endmodule

`default_nettype wire

>>> rtl/core/lru_object_cache.sv
// ----------------------------------------------------------------------------
// lru_object_cache
// Fully associative key/value cache with a true lru recency list.
// ----------------------------------------------------------------------------
// A request is taken on a rising edge with start high and busy low. busy stays
// high until the cycle in which its result is shown; out_valid is high for
// exactly one cycle with out_res, and the receiver has no way to hold it off.
// A lookup scans the entry RAM from entry 0, one entry per cycle, and stops
// at the first valid key match. A hit then moves that entry to the front of
// the recency list, which walks the list RAM one position per cycle.
// A store reads the least-recent index, writes key and value there and moves
// it to the front.
// A lookup miss is shown once the last entry has been scanned; a hit or a
// store is shown once the recency move has ended. busy is already low in
// the out_valid cycle, so the next request may be taken at the edge that
// ends it.
// After reset the valid bits clear at once and the recency RAM is filled with
// its identity order, one position per cycle; busy stays high until the fill
// is done.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_object_cache (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire loc_pkg::loc_req_t in_req,
  output logic                   out_valid,
  output loc_pkg::loc_res_t      out_res
);

  import loc_pkg::*;

  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_VICT = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_WAIT = 3'd4;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LINES - 1);

  logic [2:0]             state_r, state_nxt;
  logic [IDX_W-1:0]       scan_r, scan_nxt;
  logic [LINES-1:0]       valid_r, valid_nxt;
  logic [KEY_WIDTH-1:0]   key_r, key_nxt;
  logic [VALUE_WIDTH-1:0] val_r, val_nxt;
  logic                   out_valid_r, out_valid_nxt;
  loc_res_t               res_r, res_nxt;

  loc_lru_cmd_t           lru_cmd;
  loc_lru_sts_t           lru_sts;

  logic                   kv_we;
  logic [IDX_W-1:0]       kv_raddr;
  logic [ENTRY_W-1:0]     kv_rdata;
  logic                   match;

  loc_ram #(.WIDTH(ENTRY_W), .DEPTH(LINES)) u_entry_ram (
    .clk   (clk),
    .we    (kv_we),
    .waddr (lru_sts.victim),
    .wdata ({key_r, val_r}),
    .raddr (kv_raddr),
    .rdata (kv_rdata)
  );

  loc_lru u_lru (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (lru_cmd),
    .sts   (lru_sts)
  );

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  assign match = valid_r[scan_r] && (kv_rdata[ENTRY_W-1:VALUE_WIDTH] == key_r);

  always_comb begin
    state_nxt     = state_r;
    scan_nxt      = scan_r;
    valid_nxt     = valid_r;
    key_nxt       = key_r;
    val_nxt       = val_r;
    res_nxt       = res_r;
    out_valid_nxt = 1'b0;
    lru_cmd       = '0;
    lru_cmd.target = scan_r;
    kv_we         = 1'b0;
    kv_raddr      = scan_r + IDX_W'(1);
    unique case (state_r)
      S_INIT: begin
        if (lru_sts.ready) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        kv_raddr = '0;
        if (start) begin
          key_nxt  = to_key(in_req.lookup_key);
          val_nxt  = to_value(in_req.store_value);
          res_nxt  = '0;
          scan_nxt = '0;
          if (in_req.operation == OP_STORE) begin
            lru_cmd.rd_victim = 1'b1;
            state_nxt         = S_VICT;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_VICT: begin
        kv_we                     = 1'b1;
        valid_nxt[lru_sts.victim] = 1'b1;
        lru_cmd.promote           = 1'b1;
        lru_cmd.target            = lru_sts.victim;
        state_nxt                 = S_WAIT;
      end
      S_SCAN: begin
        if (match) begin
          res_nxt.hit        = 1'b1;
          res_nxt.read_value = from_value(kv_rdata[VALUE_WIDTH-1:0]);
          lru_cmd.promote    = 1'b1;
          state_nxt          = S_WAIT;
        end else if (scan_r == LAST_IDX) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          scan_nxt = scan_r + IDX_W'(1);
        end
      end
      S_WAIT: begin
        if (lru_sts.done) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    scan_r <= scan_nxt;
    key_r  <= key_nxt;
    val_r  <= val_nxt;
    res_r  <= res_nxt;
  end

  // a request taken always makes the block busy on the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("request accepted but block not busy");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while block busy");

  a_victim_ready: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_VICT |-> lru_sts.victim_vld)
    else $error("victim index not available from recency list");

  a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    lru_sts.done |-> state_r == S_WAIT)
    else $error("recency move ended outside of wait state");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_res.hit |-> out_res.read_value == 32'd0)
    else $error("miss or store result carries a value");

endmodule

`default_nettype wire
